FILE: src/bss_pkg.sv
// Shared types, constants and helpers for the bounded sorted set block.
package bss_pkg;

  localparam int Depth      = 64;
  localparam int DataW      = 32;
  localparam int CapW       = 7;
  localparam int IdxW       = $clog2(Depth);
  localparam int CntW       = $clog2(Depth + 1);
  localparam int MinForSpan = 2;

  typedef enum logic {
    ReqAdd  = 1'b0,
    ReqRead = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    StatInserted  = 3'd0,
    StatDuplicate = 3'd1,
    StatFull      = 3'd2,
    StatReadOk    = 3'd3,
    StatReadOor   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StFin
  } state_e;

  // Word broadcast to every cell of the chain.
  typedef struct packed {
    logic             ins;
    logic [DataW-1:0] val;
  } bss_bcast_t;

  // What one cell shows its right-hand neighbor and the controller.
  typedef struct packed {
    logic             valid;
    logic             lt;
    logic             eq;
    logic             fresh;
    logic [DataW-1:0] val;
  } bss_cell_t;

  // Neighbor gaps around a freshly inserted element.
  typedef struct packed {
    logic             lo_hit;
    logic [DataW-1:0] lo;
    logic             hi_hit;
    logic [DataW-1:0] hi;
  } bss_gap_t;

  // Flip the sign bit so an unsigned compare orders signed values.
  function automatic logic [DataW-1:0] order_key(input logic [DataW-1:0] v);
    order_key = {~v[DataW-1], v[DataW-2:0]};
  endfunction

endpackage

FILE: src/bss_cell.sv
// One slot of the sorted insertion chain: holds one element and shifts right on insert.
module bss_cell
  import bss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bss_bcast_t bcast_i,
  input  bss_cell_t  left_i,
  input  logic       right_valid_i,
  output bss_cell_t  cell_o,
  output bss_gap_t   gap_o,
  output logic [DataW-1:0] last_val_o
);

  logic             valid_q, valid_d;
  logic             fresh_q, fresh_d;
  logic [DataW-1:0] val_q, val_d;
  logic             lt;
  logic [DataW-1:0] diff;

  assign lt   = valid_q && (order_key(val_q) < order_key(bcast_i.val));
  assign diff = val_q - left_i.val;

  always_comb begin
    valid_d = valid_q;
    fresh_d = fresh_q;
    val_d   = val_q;
    if (bcast_i.ins) begin
      if (lt) begin
        fresh_d = 1'b0;
      end else if (left_i.lt) begin
        // insertion point: take the new word
        valid_d = 1'b1;
        fresh_d = 1'b1;
        val_d   = bcast_i.val;
      end else begin
        // advance the left neighbor's word
        valid_d = left_i.valid;
        fresh_d = 1'b0;
        val_d   = left_i.val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fresh_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.lt    = lt;
  assign cell_o.eq    = valid_q && (val_q == bcast_i.val);
  assign cell_o.fresh = fresh_q;
  assign cell_o.val   = val_q;

  assign gap_o.lo_hit = fresh_q && left_i.valid;
  assign gap_o.lo     = (fresh_q && left_i.valid) ? diff : '0;
  assign gap_o.hi_hit = left_i.fresh && valid_q;
  assign gap_o.hi     = (left_i.fresh && valid_q) ? diff : '0;

  assign last_val_o = (valid_q && !right_valid_i) ? val_q : '0;

endmodule

FILE: src/bounded_sorted_set_span.sv
// Top level: sorted set chain, controller and registered result word.
// Steps: the word is taken into the input register, the cell chain compares and shifts, and
//   the neighbor gaps, range and read element are gathered into the output register. A new
//   word is stalled until that gather step is done. An output stall holds the gather step.
// A new word is accepted while a finished result waits in the output register.
// Reset: the set is empty, the minimum gap is all ones and the capacity is zero.
module bounded_sorted_set_span
  import bss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CapW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [DataW-1:0]  value_i,
  input  logic [IdxW-1:0]   index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [DataW-1:0]  element_o,
  output logic [CntW-1:0]   count_o,
  output logic [DataW-1:0]  shortest_span_o,
  output logic [DataW-1:0]  longest_span_o,
  output logic              span_valid_o
);

  state_e           state_q, state_d;
  logic [CapW-1:0]  capacity_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [DataW-1:0] min_gap_q, min_gap_d;
  req_e             req_q;
  logic [DataW-1:0] value_q;
  logic [IdxW-1:0]  index_q;
  status_e          status_q, status_d;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [DataW-1:0] out_element_q, out_element_d;
  logic [CntW-1:0]  out_count_q;
  logic [DataW-1:0] out_short_q, out_short_d;
  logic [DataW-1:0] out_long_q, out_long_d;
  logic             out_span_q, out_span_d;

  bss_bcast_t       bcast;
  bss_cell_t        cell_s [Depth+1];
  bss_gap_t         gap_s  [Depth];
  logic [DataW-1:0] last_s [Depth];
  logic [Depth-1:0] vld_vec;

  logic             in_acc, load, ins, dup, full, rd_in_range;
  logic [31:0]      eff_cap;
  bss_gap_t         gap_or;
  logic [DataW-1:0] last_or;

  assign in_acc = in_valid_i && !in_stall_o;
  assign load   = (state_q == StFin) && (!out_valid_q || !out_stall_i);

  // ---------------- cell chain ----------------
  assign cell_s[0] = '{valid: 1'b0, lt: 1'b1, eq: 1'b0, fresh: 1'b0, val: '0};

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic right_valid;
    if (i == Depth - 1) begin : g_end
      assign right_valid = 1'b0;
    end else begin : g_mid
      assign right_valid = cell_s[i+2].valid;
    end
    bss_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .bcast_i      (bcast),
      .left_i       (cell_s[i]),
      .right_valid_i(right_valid),
      .cell_o       (cell_s[i+1]),
      .gap_o        (gap_s[i]),
      .last_val_o   (last_s[i])
    );
    assign vld_vec[i] = cell_s[i+1].valid;
  end

  // ---------------- gather across the chain ----------------
  always_comb begin
    dup     = 1'b0;
    gap_or  = '0;
    last_or = '0;
    for (int i = 0; i < Depth; i++) begin
      dup           = dup | cell_s[i+1].eq;
      gap_or.lo_hit = gap_or.lo_hit | gap_s[i].lo_hit;
      gap_or.lo     = gap_or.lo | gap_s[i].lo;
      gap_or.hi_hit = gap_or.hi_hit | gap_s[i].hi_hit;
      gap_or.hi     = gap_or.hi | gap_s[i].hi;
      last_or       = last_or | last_s[i];
    end
  end

  assign eff_cap     = (32'(capacity_q) > 32'(Depth)) ? 32'(Depth) : 32'(capacity_q);
  assign full        = 32'(count_q) >= eff_cap;
  assign rd_in_range = 32'(index_q) < 32'(count_q);
  assign ins         = (state_q == StExec) && (req_q == ReqAdd) && !full && !dup;

  assign bcast.ins = ins;
  assign bcast.val = value_q;

  // ---------------- control ----------------
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    count_d  = count_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) state_d = StExec;
      end
      StExec: begin
        if (req_q == ReqAdd) begin
          if (full) begin
            status_d = StatFull;
          end else if (dup) begin
            status_d = StatDuplicate;
          end else begin
            status_d = StatInserted;
            count_d  = count_q + CntW'(1);
          end
        end else begin
          status_d = rd_in_range ? StatReadOk : StatReadOor;
        end
        state_d = StFin;
      end
      StFin: begin
        if (load) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  // ---------------- result assembly ----------------
  always_comb begin
    min_gap_d = min_gap_q;
    if (status_q == StatInserted) begin
      if (gap_or.lo_hit && (gap_or.lo < min_gap_d)) min_gap_d = gap_or.lo;
      if (gap_or.hi_hit && (gap_or.hi < min_gap_d)) min_gap_d = gap_or.hi;
    end

    out_element_d = '0;
    if (req_q == ReqRead) begin
      if (rd_in_range) begin
        out_element_d = cell_s[CntW'(index_q) + CntW'(1)].val;
      end else if (count_q != '0) begin
        out_element_d = cell_s[1].val;
      end
    end

    out_span_d  = count_q >= CntW'(MinForSpan);
    out_short_d = out_span_d ? min_gap_d : '0;
    out_long_d  = out_span_d ? (last_or - cell_s[1].val) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      capacity_q  <= '0;
      count_q     <= '0;
      min_gap_q   <= '1;
      status_q    <= StatInserted;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      count_q  <= count_d;
      if (cfg_we_i) capacity_q <= cfg_wdata_i;
      if (load) begin
        min_gap_q   <= min_gap_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q   <= req_e'(req_type_i);
      value_q <= value_i;
      index_q <= index_i;
    end
    if (load) begin
      out_status_q  <= status_q;
      out_element_q <= out_element_d;
      out_count_q   <= count_q;
      out_short_q   <= out_short_d;
      out_long_q    <= out_long_d;
      out_span_q    <= out_span_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign element_o       = out_element_q;
  assign count_o         = out_count_q;
  assign shortest_span_o = out_short_q;
  assign longest_span_o  = out_long_q;
  assign span_valid_o    = out_span_q;

  // ---------------- assertions ----------------
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(vld_vec) == 32'(count_q)))
    else $error("cell valid bits disagree with element count");

  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_vec & (vld_vec + Depth'(1))) == '0))
    else $error("occupied cells are not packed from the left");

  a_insert_bumps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not advance the count");

  a_min_gap_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (min_gap_q <= $past(min_gap_q)))
    else $error("minimum gap grew");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StFin))
    else $error("result appeared outside the gather step");

endmodule
